[rtl/scsa_pkg.sv]
`timescale 1ns / 1ps

package scsa_pkg;

    localparam int unsigned NUM_CLASSES        = 6;
    localparam int unsigned CHUNK_BYTES        = 4096;
    localparam int unsigned CHUNK_HEADER_BYTES = 16;
    localparam int unsigned NUM_CHUNKS         = 64;
    localparam int unsigned SMALLEST_BLOCK     = 16;

    localparam int unsigned ADDR_W      = 18;
    localparam int unsigned BYTES_W     = 16;
    localparam int unsigned COUNT_W     = 14;
    localparam int unsigned CLS_IDX_W   = 3;

    localparam int unsigned REGION_BYTES = NUM_CHUNKS * CHUNK_BYTES;
    localparam int unsigned IDX_SHIFT    = $clog2(SMALLEST_BLOCK);
    localparam int unsigned LINK_DEPTH   = REGION_BYTES >> IDX_SHIFT;
    localparam int unsigned LINK_IDX_W   = $clog2(LINK_DEPTH);
    localparam int unsigned CLS_W        = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int unsigned OFF_W        = $clog2(CHUNK_BYTES + 1);
    localparam int unsigned CHUNK_CNT_W  = $clog2(NUM_CHUNKS + 1);
    localparam int unsigned LINK_W       = ADDR_W + 1;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic
    {
        MODE_ALLOC = 1'b0,
        MODE_FREE  = 1'b1
    } mode_t;

    typedef enum logic [1:0]
    {
        STATUS_SERVED = 2'd0,
        STATUS_PASS   = 2'd1,
        STATUS_OOM    = 2'd2,
        STATUS_NULL   = 2'd3
    } status_t;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_LOOKUP,
        ST_CARVE,
        ST_LINK_RD,
        ST_POP,
        ST_RESULT
    } state_t;

    typedef struct packed
    {
        mode_t                mode;
        logic [BYTES_W-1:0]   request_bytes;
        logic [ADDR_W-1:0]    block_address;
    } req_t;

    typedef struct packed
    {
        logic [ADDR_W-1:0]    granted_address;
        status_t              status;
        logic [CLS_IDX_W-1:0] class_index;
        logic [COUNT_W-1:0]   class_allocated;
        logic [COUNT_W-1:0]   class_free;
    } rsp_t;

    typedef struct packed
    {
        logic              valid;
        logic [ADDR_W-1:0] addr;
    } link_t;

    typedef struct packed
    {
        link_t              head;
        logic [COUNT_W-1:0] allocated;
        logic [COUNT_W-1:0] free_blocks;
    } class_entry_t;

    typedef struct packed
    {
        logic             rd_en;
        logic [CLS_W-1:0] rd_idx;
        logic             wr_en;
        logic [CLS_W-1:0] wr_idx;
        class_entry_t     wr_entry;
    } class_tbl_req_t;

    typedef struct packed
    {
        logic             hit;
        logic [CLS_W-1:0] idx;
    } class_pick_t;

    // First class whose threshold covers the size; zero bytes never hits.
    function automatic class_pick_t pick_class(logic [BYTES_W-1:0] bytes);
        class_pick_t p;
        p.hit = 1'b0;
        p.idx = '0;
        for (int k = NUM_CLASSES - 1; k >= 0; k--)
        begin
            if (bytes != '0 && 32'(bytes) <= (SMALLEST_BLOCK << k))
            begin
                p.hit = 1'b1;
                p.idx = CLS_W'(k);
            end
        end
        return p;
    endfunction

    function automatic logic [ADDR_W-1:0] class_block_size(logic [CLS_W-1:0] k);
        int unsigned s;
        s = SMALLEST_BLOCK << k;
        if (s < 8)
        begin
            s = 8;
        end
        s = (s + 7) & ~32'd7;
        return ADDR_W'(s);
    endfunction

    function automatic logic [LINK_IDX_W-1:0] link_index(logic [ADDR_W-1:0] a);
        return LINK_IDX_W'(a >> IDX_SHIFT);
    endfunction

    function automatic logic [COUNT_W-1:0] sat_add(logic [COUNT_W-1:0] c,
                                                   logic [COUNT_W-1:0] n);
        logic [COUNT_W:0] s;
        s = {1'b0, c} + {1'b0, n};
        return (s > {1'b0, COUNT_MAX}) ? COUNT_MAX : s[COUNT_W-1:0];
    endfunction

    function automatic logic [COUNT_W-1:0] sat_dec(logic [COUNT_W-1:0] c);
        return (c == '0) ? '0 : c - 1'b1;
    endfunction

endpackage

[rtl/scsa_link_ram.sv]
`timescale 1ns / 1ps

module scsa_link_ram
#(
    parameter int unsigned DEPTH = 16,
    parameter int unsigned WIDTH = 8,
    localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/scsa_class_table.sv]
`timescale 1ns / 1ps

module scsa_class_table
    import scsa_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  class_tbl_req_t tbl_req,
    output class_entry_t   rd_entry
);

    class_entry_t            mem [NUM_CLASSES];
    class_entry_t            rd_data_reg;
    logic [NUM_CLASSES-1:0]  written_reg;
    logic                    rd_written_reg;

    // An entry never written reads as an empty list with zero counts.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg    <= '0;
            rd_written_reg <= 1'b0;
        end
        else
        begin
            if (tbl_req.wr_en)
            begin
                written_reg[tbl_req.wr_idx] <= 1'b1;
            end
            if (tbl_req.rd_en)
            begin
                rd_written_reg <= written_reg[tbl_req.rd_idx];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (tbl_req.wr_en)
        begin
            mem[tbl_req.wr_idx] <= tbl_req.wr_entry;
        end
        if (tbl_req.rd_en)
        begin
            rd_data_reg <= mem[tbl_req.rd_idx];
        end
    end

    assign rd_entry = rd_written_reg ? rd_data_reg : '0;

endmodule

[rtl/size_class_slab_allocator_core.sv]
`timescale 1ns / 1ps
// A free or pass-through request goes from lookup to result. An allocate from a non-empty
// list goes through lookup, pop and result; when a chunk is carved, its blocks are written
// in the carve state before the link read and pop. One request is in flight at a time:
// a new one is taken only in idle, after the result of the last one has been issued, and the
// class table and link memory reads are registered. Reset clears the class table valid bits,
// chunk count and control; the link memory is not cleared and needs no clearing pass.

module size_class_slab_allocator_core
    import scsa_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req_data,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp_data
);

    state_t                  state_reg, state_next;
    req_t                    req_reg, req_next;
    class_pick_t             pick_reg, pick_next;
    class_entry_t            ent_reg, ent_next;
    link_t                   prev_reg, prev_next;
    logic [ADDR_W-1:0]       carve_addr_reg, carve_addr_next;
    logic [OFF_W-1:0]        off_reg, off_next;
    logic [COUNT_W-1:0]      blocks_reg, blocks_next;
    logic [CHUNK_CNT_W-1:0]  chunks_reg, chunks_next;
    logic [ADDR_W-1:0]       granted_reg, granted_next;
    status_t                 status_reg, status_next;
    logic                    commit_reg, commit_next;
    rsp_t                    rsp_reg, rsp_next;
    logic                    rsp_valid_reg, rsp_valid_next;

    class_tbl_req_t          tbl_req;
    class_entry_t            tbl_entry;

    logic                    link_wr_en;
    logic [LINK_IDX_W-1:0]   link_wr_idx;
    link_t                   link_wr_data;
    logic                    link_rd_en;
    logic [LINK_IDX_W-1:0]   link_rd_idx;
    link_t                   link_rd_data;

    logic                    req_xfer;
    logic                    rsp_slot_free;
    logic                    is_null;
    logic                    is_special;
    logic                    do_free;
    logic                    do_pop;
    logic                    do_carve;
    logic [ADDR_W-1:0]       block_bytes;
    logic                    carve_fits;

    scsa_class_table u_class_table
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .tbl_req  (tbl_req),
        .rd_entry (tbl_entry)
    );

    scsa_link_ram
    #(
        .DEPTH (LINK_DEPTH),
        .WIDTH (LINK_W)
    )
    u_link_ram
    (
        .clk     (clk),
        .wr_en   (link_wr_en),
        .wr_addr (link_wr_idx),
        .wr_data (link_wr_data),
        .rd_en   (link_rd_en),
        .rd_addr (link_rd_idx),
        .rd_data (link_rd_data)
    );

    assign req_xfer      = req_valid && req_ready;
    assign rsp_slot_free = !rsp_valid_reg || rsp_ready;

    // Request decode against the class entry returned by the table
    always_comb
    begin
        is_null    = (req_reg.mode == MODE_FREE) && (req_reg.block_address == '0);
        is_special = is_null || !pick_reg.hit ||
                     ((req_reg.mode == MODE_FREE) &&
                      (32'(req_reg.block_address) >= REGION_BYTES));
        do_free    = !is_special && (req_reg.mode == MODE_FREE);
        do_pop     = !is_special && (req_reg.mode == MODE_ALLOC) && tbl_entry.head.valid;
        do_carve   = !is_special && (req_reg.mode == MODE_ALLOC) && !tbl_entry.head.valid &&
                     (32'(chunks_reg) < NUM_CHUNKS);
        block_bytes = class_block_size(pick_reg.idx);
        carve_fits  = (32'(off_reg) + 32'(block_bytes)) <= CHUNK_BYTES;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_xfer)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                if (do_pop)
                begin
                    state_next = ST_POP;
                end
                else if (do_carve)
                begin
                    state_next = ST_CARVE;
                end
                else
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_CARVE:
            begin
                if (!carve_fits)
                begin
                    state_next = (blocks_reg != '0) ? ST_LINK_RD : ST_RESULT;
                end
            end
            ST_LINK_RD:
            begin
                state_next = ST_POP;
            end
            ST_POP:
            begin
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (rsp_slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Memory controls and handshake outputs
    always_comb
    begin
        req_ready        = 1'b0;
        tbl_req          = '0;
        link_wr_en       = 1'b0;
        link_wr_idx      = '0;
        link_wr_data     = '0;
        link_rd_en       = 1'b0;
        link_rd_idx      = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_ready      = 1'b1;
                tbl_req.rd_en  = req_xfer;
                tbl_req.rd_idx = pick_next.idx;
            end
            ST_LOOKUP:
            begin
                // push: the freed block links to the old head
                link_wr_en   = do_free;
                link_wr_idx  = link_index(req_reg.block_address);
                link_wr_data = tbl_entry.head;
                link_rd_en   = do_pop;
                link_rd_idx  = link_index(tbl_entry.head.addr);
            end
            ST_CARVE:
            begin
                link_wr_en   = carve_fits;
                link_wr_idx  = link_index(carve_addr_reg);
                link_wr_data = prev_reg;
            end
            ST_LINK_RD:
            begin
                link_rd_en  = 1'b1;
                link_rd_idx = link_index(ent_reg.head.addr);
            end
            ST_POP:
            begin
            end
            ST_RESULT:
            begin
                tbl_req.wr_en    = rsp_slot_free && commit_reg;
                tbl_req.wr_idx   = pick_reg.idx;
                tbl_req.wr_entry = ent_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        req_next        = req_reg;
        pick_next       = pick_reg;
        ent_next        = ent_reg;
        prev_next       = prev_reg;
        carve_addr_next = carve_addr_reg;
        off_next        = off_reg;
        blocks_next     = blocks_reg;
        chunks_next     = chunks_reg;
        granted_next    = granted_reg;
        status_next     = status_reg;
        commit_next     = commit_reg;
        rsp_next        = rsp_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp_ready;

        case (state_reg)
            ST_IDLE:
            begin
                if (req_xfer)
                begin
                    req_next  = req_data;
                    pick_next = pick_class(req_data.request_bytes);
                end
            end
            ST_LOOKUP:
            begin
                ent_next     = tbl_entry;
                granted_next = '0;
                commit_next  = 1'b0;
                status_next  = STATUS_OOM;
                if (is_null)
                begin
                    status_next = STATUS_NULL;
                end
                else if (is_special)
                begin
                    status_next = STATUS_PASS;
                end
                else if (do_free)
                begin
                    ent_next.head.valid  = 1'b1;
                    ent_next.head.addr   = req_reg.block_address;
                    ent_next.allocated   = sat_dec(tbl_entry.allocated);
                    ent_next.free_blocks = sat_add(tbl_entry.free_blocks, COUNT_W'(1));
                    status_next          = STATUS_SERVED;
                    commit_next          = 1'b1;
                end
                else if (do_carve)
                begin
                    carve_addr_next = ADDR_W'(32'(chunks_reg) * CHUNK_BYTES + CHUNK_HEADER_BYTES);
                    off_next        = OFF_W'(CHUNK_HEADER_BYTES);
                    blocks_next     = '0;
                    prev_next       = tbl_entry.head;
                end
            end
            ST_CARVE:
            begin
                if (carve_fits)
                begin
                    prev_next.valid = 1'b1;
                    prev_next.addr  = carve_addr_reg;
                    carve_addr_next = carve_addr_reg + block_bytes;
                    off_next        = off_reg + OFF_W'(block_bytes);
                    blocks_next     = blocks_reg + 1'b1;
                end
                else
                begin
                    // chunk is consumed even when no block fits
                    chunks_next          = chunks_reg + 1'b1;
                    ent_next.head        = prev_reg;
                    ent_next.free_blocks = sat_add(ent_reg.free_blocks, blocks_reg);
                    commit_next          = 1'b1;
                end
            end
            ST_POP:
            begin
                granted_next         = ent_reg.head.addr;
                ent_next.head        = link_rd_data;
                ent_next.allocated   = sat_add(ent_reg.allocated, COUNT_W'(1));
                ent_next.free_blocks = sat_dec(ent_reg.free_blocks);
                status_next          = STATUS_SERVED;
                commit_next          = 1'b1;
            end
            ST_RESULT:
            begin
                if (rsp_slot_free)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_next       = '0;
                    rsp_next.status = status_reg;
                    if (status_reg == STATUS_SERVED || status_reg == STATUS_OOM)
                    begin
                        rsp_next.granted_address = granted_reg;
                        rsp_next.class_index     = CLS_IDX_W'(pick_reg.idx);
                        rsp_next.class_allocated = ent_reg.allocated;
                        rsp_next.class_free      = ent_reg.free_blocks;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            chunks_reg    <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            chunks_reg    <= chunks_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg        <= req_next;
        pick_reg       <= pick_next;
        ent_reg        <= ent_next;
        prev_reg       <= prev_next;
        carve_addr_reg <= carve_addr_next;
        off_reg        <= off_next;
        blocks_reg     <= blocks_next;
        granted_reg    <= granted_next;
        status_reg     <= status_next;
        commit_reg     <= commit_next;
        rsp_reg        <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

endmodule

[rtl/scsa_checker.sv]
`timescale 1ns / 1ps

module scsa_checker
    import scsa_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_ready,
    input logic rsp_valid,
    input logic rsp_ready,
    input rsp_t rsp_data
);

    // Pass-through and null results carry nothing but the status
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_data.status == STATUS_NULL || rsp_data.status == STATUS_PASS)
        |-> rsp_data.granted_address == '0 && rsp_data.class_index == '0 &&
            rsp_data.class_allocated == '0 && rsp_data.class_free == '0)
        else $error("pass-through or null result carries data");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.status == STATUS_OOM |-> rsp_data.granted_address == '0)
        else $error("out-of-memory result grants an address");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> 32'(rsp_data.class_index) < NUM_CLASSES)
        else $error("class index out of range");

    // One request in flight: no transfer on the cycle after a transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while one is in flight");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
        else $error("stalled result dropped or changed");

endmodule

bind size_class_slab_allocator_core scsa_checker u_scsa_checker (.*);
